/* hdl/e2c_pkg.sv */
// ----------------------------------------------------------------------------
// e2c_pkg
// Shared constants and restoring-division helpers for the nanosecond to
// calendar converter.
// ----------------------------------------------------------------------------
package e2c_pkg;

	localparam int NS_STAGES    = 7;
	localparam int NS_STEPS     = 5;
	localparam int DAY_STAGES   = 3;
	localparam int DAY_STEPS    = 6;
	localparam int CIVIL_STAGES = 5;
	localparam int LATENCY      = NS_STAGES + DAY_STAGES + CIVIL_STAGES;

	// 86400 * 106752 seconds, in nanoseconds
	localparam logic [64:0] NS_OFFSET   = 65'd9223372800000000000;
	localparam logic [19:0] MARCH_SHIFT = 20'd612716;
	localparam logic [17:0] LAST_DOE    = 18'd146096;

	localparam logic [29:0] D_NS_PER_SEC  = 30'd1000000000;
	localparam logic [29:0] D_SEC_PER_DAY = 30'd86400;
	localparam logic [29:0] D_ERA         = 30'd146097;
	localparam logic [29:0] D_1460        = 30'd1460;
	localparam logic [29:0] D_36524       = 30'd36524;
	localparam logic [29:0] D_365         = 30'd365;
	localparam logic [29:0] D_100         = 30'd100;
	localparam logic [29:0] D_153         = 30'd153;
	localparam logic [29:0] D_3600        = 30'd3600;
	localparam logic [29:0] D_60          = 30'd60;
	localparam logic [29:0] D_1E6         = 30'd1000000;
	localparam logic [29:0] D_1000        = 30'd1000;

	typedef struct packed {
		logic        q;
		logic [29:0] r;
	} dstep_t;

	typedef struct packed {
		logic [29:0] r;
		logic [9:0]  w;
	} div_res_t;

	function automatic dstep_t div_step(input logic [29:0] r, input logic b,
			input logic [29:0] d);
		logic [30:0] t;
		dstep_t      o;
		t = {r, b};
		if (t >= {1'b0, d}) begin
			o.q = 1'b1;
			o.r = 30'(t - {1'b0, d});
		end else begin
			o.q = 1'b0;
			o.r = t[29:0];
		end
		return o;
	endfunction

	// n restoring steps; dividend bits enter from the top of w, quotient leaves in w[n-1:0]
	function automatic div_res_t div_bits(input logic [29:0] r0, input logic [9:0] w0,
			input logic [29:0] d, input logic [3:0] n);
		div_res_t o;
		dstep_t   st;
		o.r = r0;
		o.w = w0;
		for (int i = 0; i < 10; i++) begin
			if (4'(i) < n) begin
				st  = div_step(o.r, o.w[9], d);
				o.r = st.r;
				o.w = {o.w[8:0], st.q};
			end
		end
		return o;
	endfunction

	// first March-based day of each month
	function automatic logic [8:0] month_start(input logic [3:0] mp);
		logic [8:0] v;
		case (mp)
			4'd0:    v = 9'd0;
			4'd1:    v = 9'd31;
			4'd2:    v = 9'd61;
			4'd3:    v = 9'd92;
			4'd4:    v = 9'd122;
			4'd5:    v = 9'd153;
			4'd6:    v = 9'd184;
			4'd7:    v = 9'd214;
			4'd8:    v = 9'd245;
			4'd9:    v = 9'd275;
			4'd10:   v = 9'd306;
			4'd11:   v = 9'd337;
			default: v = 9'd0;
		endcase
		return v;
	endfunction

endpackage

/* hdl/e2c_civil.sv */
// ----------------------------------------------------------------------------
// e2c_civil
// Five-stage pipeline from an offset day count to year, month and day.
// ----------------------------------------------------------------------------
module e2c_civil (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic [17:0] days_off,
	output logic        out_valid,
	output logic [11:0] year,
	output logic [3:0]  month,
	output logic [4:0]  day_of_month
);

	logic [e2c_pkg::CIVIL_STAGES-1:0] v_s;

	logic [2:0]  era_s1, era_s2, era_s3, era_s4;
	logic [17:0] doe_s1, doe_s2, doe_s3;
	logic [17:0] num_s2;
	logic [8:0]  yoe_s3, yoe_s4;
	logic [8:0]  doy_s4;
	logic [11:0] year_s5;
	logic [3:0]  month_s5;
	logic [4:0]  day_s5;

	logic [19:0]         z;
	e2c_pkg::div_res_t   era_d, a_d, b_d, yoe_d, cen_d, mp_d;
	logic [17:0]         num_c;
	logic [8:0]          doy_c;
	logic [10:0]         n_c;
	logic [3:0]          mp_c, month_c;
	logic [8:0]          day_c;
	logic [11:0]         year_c;

	always_comb begin
		z     = 20'(days_off) + e2c_pkg::MARCH_SHIFT;
		era_d = e2c_pkg::div_bits(30'(z[19:3]), {z[2:0], 7'd0}, e2c_pkg::D_ERA, 4'd3);

		a_d   = e2c_pkg::div_bits(30'(doe_s1[17:7]), {doe_s1[6:0], 3'd0},
				e2c_pkg::D_1460, 4'd7);
		b_d   = e2c_pkg::div_bits(30'(doe_s1[17:3]), {doe_s1[2:0], 7'd0},
				e2c_pkg::D_36524, 4'd3);
		num_c = doe_s1 - 18'(a_d.w[6:0]) + 18'(b_d.w[2:0])
				- 18'(doe_s1 == e2c_pkg::LAST_DOE);

		yoe_d = e2c_pkg::div_bits(30'(num_s2[17:9]), {num_s2[8:0], 1'b0},
				e2c_pkg::D_365, 4'd9);

		cen_d = e2c_pkg::div_bits(30'(yoe_s3[8:2]), {yoe_s3[1:0], 8'd0},
				e2c_pkg::D_100, 4'd2);
		doy_c = 9'(doe_s3 - (18'(yoe_s3) * 18'd365 + 18'(yoe_s3[8:2])
				- 18'(cen_d.w[1:0])));

		n_c     = 11'(doy_s4) * 11'd5 + 11'd2;
		mp_d    = e2c_pkg::div_bits(30'(n_c[10:4]), {n_c[3:0], 6'd0},
				e2c_pkg::D_153, 4'd4);
		mp_c    = mp_d.w[3:0];
		day_c   = doy_s4 - e2c_pkg::month_start(mp_c) + 9'd1;
		month_c = (mp_c < 4'd10) ? mp_c + 4'd3 : mp_c - 4'd9;
		year_c  = 12'(era_s4) * 12'd400 + 12'(yoe_s4) + 12'(month_c <= 4'd2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else begin
			v_s <= {v_s[e2c_pkg::CIVIL_STAGES-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		era_s1   <= era_d.w[2:0];
		doe_s1   <= era_d.r[17:0];
		era_s2   <= era_s1;
		doe_s2   <= doe_s1;
		num_s2   <= num_c;
		era_s3   <= era_s2;
		doe_s3   <= doe_s2;
		yoe_s3   <= yoe_d.w[8:0];
		era_s4   <= era_s3;
		yoe_s4   <= yoe_s3;
		doy_s4   <= doy_c;
		year_s5  <= year_c;
		month_s5 <= month_c;
		day_s5   <= day_c[4:0];
	end

	assign out_valid    = v_s[e2c_pkg::CIVIL_STAGES-1];
	assign year         = year_s5;
	assign month        = month_s5;
	assign day_of_month = day_s5;

endmodule

/* hdl/e2c_tod.sv */
// ----------------------------------------------------------------------------
// e2c_tod
// Five-stage pipeline splitting seconds of day and sub-second nanoseconds
// into clock fields.
// ----------------------------------------------------------------------------
module e2c_tod (
	input  logic        clk,
	input  logic [16:0] sod,
	input  logic [29:0] sub,
	output logic [4:0]  hour,
	output logic [5:0]  minute,
	output logic [5:0]  second,
	output logic [9:0]  millisecond,
	output logic [9:0]  microsecond,
	output logic [9:0]  nanosecond
);

	logic [4:0]  hour_s1, hour_s2, hour_s3, hour_s4, hour_s5;
	logic [11:0] hrem_s1;
	logic [5:0]  min_s2, min_s3, min_s4, min_s5;
	logic [5:0]  sec_s2, sec_s3, sec_s4, sec_s5;
	logic [19:0] msr_s1, msr_s2;
	logic [9:0]  msw_s1;
	logic [9:0]  ms_s2, ms_s3, ms_s4, ms_s5;
	logic [9:0]  usr_s3;
	logic [9:0]  usw_s3;
	logic [9:0]  us_s4, us_s5, ns_s4, ns_s5;

	e2c_pkg::div_res_t h_d, m1_d, mi_d, m2_d, u1_d, u2_d;

	always_comb begin
		h_d  = e2c_pkg::div_bits(30'(sod[16:5]), {sod[4:0], 5'd0}, e2c_pkg::D_3600, 4'd5);
		m1_d = e2c_pkg::div_bits(30'(sub[29:10]), {sub[9:5], 5'd0}, e2c_pkg::D_1E6, 4'd5);
		mi_d = e2c_pkg::div_bits(30'(hrem_s1[11:6]), {hrem_s1[5:0], 4'd0},
				e2c_pkg::D_60, 4'd6);
		m2_d = e2c_pkg::div_bits(30'(msr_s1), {msw_s1[9:5], 5'd0}, e2c_pkg::D_1E6, 4'd5);
		u1_d = e2c_pkg::div_bits(30'(msr_s2[19:10]), {msr_s2[9:5], 5'd0},
				e2c_pkg::D_1000, 4'd5);
		u2_d = e2c_pkg::div_bits(30'(usr_s3), {usw_s3[9:5], 5'd0}, e2c_pkg::D_1000, 4'd5);
	end

	always_ff @(posedge clk) begin
		hour_s1 <= h_d.w[4:0];
		hrem_s1 <= h_d.r[11:0];
		msr_s1  <= m1_d.r[19:0];
		msw_s1  <= {sub[4:0], m1_d.w[4:0]};

		hour_s2 <= hour_s1;
		min_s2  <= mi_d.w[5:0];
		sec_s2  <= mi_d.r[5:0];
		ms_s2   <= {msw_s1[4:0], m2_d.w[4:0]};
		msr_s2  <= m2_d.r[19:0];

		hour_s3 <= hour_s2;
		min_s3  <= min_s2;
		sec_s3  <= sec_s2;
		ms_s3   <= ms_s2;
		usr_s3  <= u1_d.r[9:0];
		usw_s3  <= {msr_s2[4:0], u1_d.w[4:0]};

		hour_s4 <= hour_s3;
		min_s4  <= min_s3;
		sec_s4  <= sec_s3;
		ms_s4   <= ms_s3;
		us_s4   <= {usw_s3[4:0], u2_d.w[4:0]};
		ns_s4   <= u2_d.r[9:0];

		hour_s5 <= hour_s4;
		min_s5  <= min_s4;
		sec_s5  <= sec_s4;
		ms_s5   <= ms_s4;
		us_s5   <= us_s4;
		ns_s5   <= ns_s4;
	end

	assign hour        = hour_s5;
	assign minute      = min_s5;
	assign second      = sec_s5;
	assign millisecond = ms_s5;
	assign microsecond = us_s5;
	assign nanosecond  = ns_s5;

endmodule

/* hdl/epoch_ns_to_calendar_core.sv */
// ----------------------------------------------------------------------------
// epoch_ns_to_calendar_core
// Signed nanoseconds since 1970-01-01 UTC to Gregorian date and time of day.
//
//   channel   handshake          payload
//   input     start / busy       time_ns
//   result    done (one cycle)   year .. nanosecond
//
// One item per cycle; each result is taken once its transfer has passed through
// the restoring divider chain (7 stages for 1e9, 3 for 86400, 5 for
// the date and clock fields). busy stays low: the pipeline never stalls and
// the receiver takes every result. Reset clears only the valid bits.
// ----------------------------------------------------------------------------
module epoch_ns_to_calendar_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [63:0] time_ns,
	output logic               done,
	output logic [11:0]        year,
	output logic [3:0]         month,
	output logic [4:0]         day_of_month,
	output logic [4:0]         hour,
	output logic [5:0]         minute,
	output logic [5:0]         second,
	output logic [9:0]         millisecond,
	output logic [9:0]         microsecond,
	output logic [9:0]         nanosecond
);

	typedef struct packed {
		logic [29:0] r;
		logic [34:0] w;
	} ns_div_t;

	typedef struct packed {
		logic [16:0] r;
		logic [17:0] w;
	} day_div_t;

	function automatic ns_div_t ns_stage(input ns_div_t a);
		ns_div_t           o;
		e2c_pkg::div_res_t d;
		d   = e2c_pkg::div_bits(a.r, {a.w[34:30], 5'd0}, e2c_pkg::D_NS_PER_SEC,
				4'(e2c_pkg::NS_STEPS));
		o.r = d.r;
		o.w = {a.w[29:0], d.w[4:0]};
		return o;
	endfunction

	function automatic day_div_t day_stage(input day_div_t a);
		day_div_t          o;
		e2c_pkg::div_res_t d;
		d   = e2c_pkg::div_bits(30'(a.r), {a.w[17:12], 4'd0}, e2c_pkg::D_SEC_PER_DAY,
				4'(e2c_pkg::DAY_STEPS));
		o.r = d.r[16:0];
		o.w = {a.w[11:0], d.w[5:0]};
		return o;
	endfunction

	logic [64:0] u;
	logic        take;

	ns_div_t  ns_nx  [e2c_pkg::NS_STAGES];
	ns_div_t  ns_s   [e2c_pkg::NS_STAGES];
	logic [e2c_pkg::NS_STAGES-1:0] ns_v_s;

	day_div_t    day_nx  [e2c_pkg::DAY_STAGES];
	day_div_t    day_s   [e2c_pkg::DAY_STAGES];
	logic [29:0] sub_s   [e2c_pkg::DAY_STAGES];
	logic [e2c_pkg::DAY_STAGES-1:0] day_v_s;

	assign busy = 1'b0;
	assign take = start & ~busy;
	assign u    = 65'({time_ns[63], time_ns}) + e2c_pkg::NS_OFFSET;

	always_comb begin
		ns_nx[0] = ns_stage(u);
		for (int k = 1; k < e2c_pkg::NS_STAGES; k++) begin
			ns_nx[k] = ns_stage(ns_s[k-1]);
		end
		day_nx[0] = day_stage(ns_s[e2c_pkg::NS_STAGES-1].w);
		for (int k = 1; k < e2c_pkg::DAY_STAGES; k++) begin
			day_nx[k] = day_stage(day_s[k-1]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ns_v_s  <= '0;
			day_v_s <= '0;
		end else begin
			ns_v_s  <= {ns_v_s[e2c_pkg::NS_STAGES-2:0], take};
			day_v_s <= {day_v_s[e2c_pkg::DAY_STAGES-2:0], ns_v_s[e2c_pkg::NS_STAGES-1]};
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < e2c_pkg::NS_STAGES; k++) begin
			ns_s[k] <= ns_nx[k];
		end
		sub_s[0] <= ns_s[e2c_pkg::NS_STAGES-1].r;
		for (int k = 0; k < e2c_pkg::DAY_STAGES; k++) begin
			day_s[k] <= day_nx[k];
		end
		for (int k = 1; k < e2c_pkg::DAY_STAGES; k++) begin
			sub_s[k] <= sub_s[k-1];
		end
	end

	e2c_civil u_civil (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (day_v_s[e2c_pkg::DAY_STAGES-1]),
		.days_off     (day_s[e2c_pkg::DAY_STAGES-1].w),
		.out_valid    (done),
		.year         (year),
		.month        (month),
		.day_of_month (day_of_month)
	);

	e2c_tod u_tod (
		.clk         (clk),
		.sod         (day_s[e2c_pkg::DAY_STAGES-1].r),
		.sub         (sub_s[e2c_pkg::DAY_STAGES-1]),
		.hour        (hour),
		.minute      (minute),
		.second      (second),
		.millisecond (millisecond),
		.microsecond (microsecond),
		.nanosecond  (nanosecond)
	);

endmodule

/* hdl/e2c_chk.sv */
// ----------------------------------------------------------------------------
// e2c_chk
// Port-level checks for the nanosecond to calendar converter.
// ----------------------------------------------------------------------------
module e2c_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic signed [63:0] time_ns,
	input logic               done,
	input logic [11:0]        year,
	input logic [3:0]         month,
	input logic [4:0]         day_of_month,
	input logic [4:0]         hour,
	input logic [5:0]         minute,
	input logic [5:0]         second,
	input logic [9:0]         millisecond,
	input logic [9:0]         microsecond,
	input logic [9:0]         nanosecond
);

	a_done_follows_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, e2c_pkg::LATENCY))
		else $error("result without a matching transfer");

	a_date_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (month >= 4'd1 && month <= 4'd12 && day_of_month >= 5'd1
			&& year >= 12'd1677 && year <= 12'd2262))
		else $error("date field out of range");

	a_clock_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (hour <= 5'd23 && minute <= 6'd59 && second <= 6'd59
			&& millisecond <= 10'd999 && microsecond <= 10'd999 && nanosecond <= 10'd999))
		else $error("clock field out of range");

	a_epoch: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(time_ns, e2c_pkg::LATENCY) == 64'sd0) |->
			(year == 12'd1970 && month == 4'd1 && day_of_month == 5'd1 && hour == 5'd0
			&& nanosecond == 10'd0))
		else $error("epoch converts wrongly");

endmodule

bind epoch_ns_to_calendar_core e2c_chk u_e2c_chk (.*);
